// ----- rtl/joystick_average_deadzone_mapper_defines.svh -----
// ----------------------------------------------------------------------------
// Joystick mapper assertion macros
// Shared concurrent assertion forms; clk and rst_n come from the using scope.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_AVERAGE_DEADZONE_MAPPER_DEFINES_SVH
`define JOYSTICK_AVERAGE_DEADZONE_MAPPER_DEFINES_SVH

// same-cycle implication
`define JADM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JADM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/jadm_pkg.sv -----
// ----------------------------------------------------------------------------
// Joystick mapper package
// Field widths, codes and fixed reciprocal constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jadm_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int SPEED_W    = 7;
  localparam int HEAD_W     = 2;
  localparam int LIGHT_W    = 7;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // out_tdata bit positions
  localparam int SPEED_LSB = 0;
  localparam int HEAD_LSB  = SPEED_LSB + SPEED_W;
  localparam int LIGHT_LSB = HEAD_LSB + HEAD_W;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef enum logic [HEAD_W-1:0] {
    HEAD_NORTH = 2'd0,
    HEAD_EAST  = 2'd1,
    HEAD_SOUTH = 2'd2,
    HEAD_WEST  = 2'd3
  } heading_t;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE = 1'b1;

  localparam sample_t CENTRE_RESET   = 12'd2048;
  localparam sample_t DEADZONE_RESET = 12'd800;

  localparam logic [SPEED_W-1:0] PERCENT_MAX = 7'd100;

  // light: floor(ls*100/4095) as (ls*100) * ceil(2^31/4095) >> 31
  localparam int LIGHT_PROD_W  = 19;
  localparam int LIGHT_K       = 31;
  localparam int LIGHT_RECIP_W = 20;
  localparam int LIGHT_MUL_W   = LIGHT_PROD_W + LIGHT_RECIP_W;
  localparam logic [LIGHT_RECIP_W-1:0] LIGHT_RECIP =
    LIGHT_RECIP_W'(((64'd1 << LIGHT_K) + 64'd4094) / 64'd4095);
  localparam logic [LIGHT_PROD_W-1:0] LIGHT_SCALE = 19'd100;

  // speed: dev*100/1000 == floor(dev/10), via ceil(2^16/10) >> 16
  localparam int DEV_K       = 16;
  localparam int DEV_RECIP_W = 13;
  localparam int DEV_MUL_W   = SAMPLE_W + DEV_RECIP_W;
  localparam int SPEED_Q_W   = 9;
  localparam logic [DEV_RECIP_W-1:0] DEV_RECIP =
    DEV_RECIP_W'(((64'd1 << DEV_K) + 64'd9) / 64'd10);

  typedef struct packed {
    logic filled_now;
    logic filled_next;
  } win_status_t;

endpackage

// ----- rtl/jadm_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jadm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/jadm_window.sv -----
// ----------------------------------------------------------------------------
// Moving-average window
// Sample ring in RAM, running sums, write pointer and fill flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jadm_window import jadm_pkg::*; #(
  parameter int WINDOW_LENGTH = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    accept,
  input  sample_t                                 x_sample,
  input  sample_t                                 y_sample,
  output logic [SAMPLE_W+$clog2(WINDOW_LENGTH)-1:0] x_sum_nxt,
  output logic [SAMPLE_W+$clog2(WINDOW_LENGTH)-1:0] y_sum_nxt,
  output win_status_t                             status
);

  localparam int PTR_W = $clog2(WINDOW_LENGTH);
  localparam int SUM_W = SAMPLE_W + PTR_W;

  logic [PTR_W-1:0]      pos_r, pos_nxt;
  logic                  filled_r, filled_nxt;
  logic [SUM_W-1:0]      x_sum_r, y_sum_r;
  logic [2*SAMPLE_W-1:0] rd_data;
  sample_t               x_old, y_old;
  logic                  wrap;

  // the read runs one entry ahead so the oldest sample is ready on accept
  jadm_ram #(
    .WIDTH (2 * SAMPLE_W),
    .DEPTH (WINDOW_LENGTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (pos_r),
    .wr_data ({y_sample, x_sample}),
    .rd_addr (pos_nxt),
    .rd_data (rd_data)
  );

  always_comb begin
    wrap       = (pos_r == PTR_W'(WINDOW_LENGTH - 1));
    pos_nxt    = pos_r;
    filled_nxt = filled_r;
    if (accept) begin
      pos_nxt = wrap ? '0 : pos_r + PTR_W'(1);
      if (wrap) begin
        filled_nxt = 1'b1;
      end
    end
  end

  // entries not yet written in the first pass read as zero
  always_comb begin
    x_old     = filled_r ? rd_data[SAMPLE_W-1:0] : '0;
    y_old     = filled_r ? rd_data[2*SAMPLE_W-1:SAMPLE_W] : '0;
    x_sum_nxt = x_sum_r;
    y_sum_nxt = y_sum_r;
    if (accept) begin
      x_sum_nxt = x_sum_r - SUM_W'(x_old) + SUM_W'(x_sample);
      y_sum_nxt = y_sum_r - SUM_W'(y_old) + SUM_W'(y_sample);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      filled_r <= 1'b0;
      x_sum_r  <= '0;
      y_sum_r  <= '0;
    end else begin
      pos_r    <= pos_nxt;
      filled_r <= filled_nxt;
      x_sum_r  <= x_sum_nxt;
      y_sum_r  <= y_sum_nxt;
    end
  end

  assign status.filled_now  = filled_r;
  assign status.filled_next = filled_nxt;

endmodule

// ----- rtl/joystick_average_deadzone_mapper.sv -----
// Pipeline: an accepted request passes registers p1, p2, p3, p4 and then the output register
// (window update, average multiply, deviation, deadzone/light quotient, speed scale).
// Throughput: one request per cycle; each stage stalls only if the one after is full.
// Reset: centre 2048, deadzone 800, window empty, heading north; the sample ring
// is not cleared, unwritten entries are masked by the fill flag.
// ----------------------------------------------------------------------------
// Joystick average deadzone mapper
// Moving-average X/Y with deadzone to speed and heading, plus light percent.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "joystick_average_deadzone_mapper_defines.svh"

module joystick_average_deadzone_mapper import jadm_pkg::*; #(
  parameter int WINDOW_LENGTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [11:0] x_sample, [23:12] y_sample, [35:24] light_sample, [39:36] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [6:0] speed_percent, [8:7] heading, [15:9] light_percent
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SAMPLE_W-1:0]   cfg_wdata
);

  localparam int PTR_W = $clog2(WINDOW_LENGTH);
  localparam int SUM_W = SAMPLE_W + PTR_W;
  localparam int AVG_K = SUM_W + PTR_W;
  localparam int M_W   = SUM_W + 1;
  localparam int AVG_MUL_W = SUM_W + M_W;
  localparam logic [M_W-1:0] AVG_RECIP =
    M_W'(((64'd1 << AVG_K) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH));

  // configuration
  sample_t centre_r, deadzone_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_r   <= CENTRE_RESET;
      deadzone_r <= DEADZONE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CENTRE:   centre_r   <= cfg_wdata;
        CFG_DEADZONE: deadzone_r <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // stage ready chain
  logic p1_v_r, p2_v_r, p3_v_r, p4_v_r, out_v_r;
  logic rdy2, rdy3, rdy4, rdy_out, in_acc;

  assign rdy_out   = !out_v_r || out_tready;
  assign rdy4      = !p4_v_r || rdy_out;
  assign rdy3      = !p3_v_r || rdy4;
  assign rdy2      = !p2_v_r || rdy3;
  assign in_tready = !p1_v_r || rdy2;
  assign in_acc    = in_tvalid && in_tready;

  // stage 0: window update
  sample_t          in_x, in_y, in_l;
  logic [SUM_W-1:0] x_sum_nxt, y_sum_nxt;
  win_status_t      win_st;

  assign in_x = in_tdata[SAMPLE_W-1:0];
  assign in_y = in_tdata[2*SAMPLE_W-1:SAMPLE_W];
  assign in_l = in_tdata[3*SAMPLE_W-1:2*SAMPLE_W];

  jadm_window #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_acc),
    .x_sample  (in_x),
    .y_sample  (in_y),
    .x_sum_nxt (x_sum_nxt),
    .y_sum_nxt (y_sum_nxt),
    .status    (win_st)
  );

  sample_t          p1_x_r, p1_y_r, p1_l_r;
  logic [SUM_W-1:0] p1_xsum_r, p1_ysum_r;
  logic             p1_filled_r;

  always_ff @(posedge clk) begin
    if (in_tready) begin
      p1_x_r      <= in_x;
      p1_y_r      <= in_y;
      p1_l_r      <= in_l;
      p1_xsum_r   <= x_sum_nxt;
      p1_ysum_r   <= y_sum_nxt;
      p1_filled_r <= win_st.filled_next;
    end
  end

  // stage 1: averages (reciprocal multiply) and light scale
  logic [AVG_MUL_W-1:0]    x_prod, y_prod;
  sample_t                 x_avg_nxt, y_avg_nxt;
  logic [LIGHT_PROD_W-1:0] l100_nxt;
  sample_t                 p2_xavg_r, p2_yavg_r;
  logic [LIGHT_PROD_W-1:0] p2_l100_r;

  always_comb begin
    x_prod    = AVG_MUL_W'(p1_xsum_r) * AVG_MUL_W'(AVG_RECIP);
    y_prod    = AVG_MUL_W'(p1_ysum_r) * AVG_MUL_W'(AVG_RECIP);
    x_avg_nxt = p1_filled_r ? x_prod[AVG_K +: SAMPLE_W] : p1_x_r;
    y_avg_nxt = p1_filled_r ? y_prod[AVG_K +: SAMPLE_W] : p1_y_r;
    l100_nxt  = LIGHT_PROD_W'(p1_l_r) * LIGHT_SCALE;
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      p2_xavg_r <= x_avg_nxt;
      p2_yavg_r <= y_avg_nxt;
      p2_l100_r <= l100_nxt;
    end
  end

  // stage 2: deviation from centre, magnitude and sign
  logic signed [SAMPLE_W:0] dx, dy;
  sample_t                  ax_nxt, ay_nxt;
  sample_t                  p3_ax_r, p3_ay_r;
  logic                     p3_xpos_r, p3_ypos_r;
  logic [LIGHT_PROD_W-1:0]  p3_l100_r;

  always_comb begin
    dx     = $signed({1'b0, p2_xavg_r}) - $signed({1'b0, centre_r});
    dy     = $signed({1'b0, p2_yavg_r}) - $signed({1'b0, centre_r});
    ax_nxt = dx[SAMPLE_W] ? SAMPLE_W'(-dx) : dx[SAMPLE_W-1:0];
    ay_nxt = dy[SAMPLE_W] ? SAMPLE_W'(-dy) : dy[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      p3_ax_r   <= ax_nxt;
      p3_ay_r   <= ay_nxt;
      p3_xpos_r <= !dx[SAMPLE_W] && (dx != '0);
      p3_ypos_r <= !dy[SAMPLE_W] && (dy != '0);
      p3_l100_r <= p2_l100_r;
    end
  end

  // stage 3: deadzone, heading candidate, light quotient
  sample_t                 dev_max, dev_nxt;
  heading_t                cand_nxt;
  logic [LIGHT_MUL_W-1:0]  light_prod;
  logic [LIGHT_W-1:0]      light_nxt;
  sample_t                 p4_dev_r;
  heading_t                p4_cand_r;
  logic [LIGHT_W-1:0]      p4_light_r;

  always_comb begin
    dev_max = (p3_ax_r > p3_ay_r) ? p3_ax_r : p3_ay_r;
    dev_nxt = (dev_max < deadzone_r) ? '0 : dev_max - deadzone_r;
    // ties go to X
    if (p3_ax_r >= p3_ay_r) begin
      cand_nxt = p3_xpos_r ? HEAD_EAST : HEAD_WEST;
    end else begin
      cand_nxt = p3_ypos_r ? HEAD_SOUTH : HEAD_NORTH;
    end
    light_prod = LIGHT_MUL_W'(p3_l100_r) * LIGHT_MUL_W'(LIGHT_RECIP);
    light_nxt  = PERCENT_MAX - light_prod[LIGHT_K +: LIGHT_W];
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      p4_dev_r   <= dev_nxt;
      p4_cand_r  <= cand_nxt;
      p4_light_r <= light_nxt;
    end
  end

  // stage 4: speed scale and saturation, heading hold
  logic [DEV_MUL_W-1:0]  speed_prod;
  logic [SPEED_Q_W-1:0]  speed_q;
  logic [SPEED_W-1:0]    speed_nxt;
  heading_t              head_nxt, held_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic                  out_load;

  always_comb begin
    speed_prod = DEV_MUL_W'(p4_dev_r) * DEV_MUL_W'(DEV_RECIP);
    speed_q    = speed_prod[DEV_K +: SPEED_Q_W];
    speed_nxt  = (speed_q > SPEED_Q_W'(PERCENT_MAX)) ? PERCENT_MAX : speed_q[SPEED_W-1:0];
    head_nxt   = (p4_dev_r != '0) ? p4_cand_r : held_r;
  end

  assign out_load = rdy_out && p4_v_r;

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {p4_light_r, head_nxt, speed_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      p3_v_r  <= 1'b0;
      p4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      held_r  <= HEAD_NORTH;
    end else begin
      if (in_tready) p1_v_r  <= in_tvalid;
      if (rdy2)      p2_v_r  <= p1_v_r;
      if (rdy3)      p3_v_r  <= p2_v_r;
      if (rdy4)      p4_v_r  <= p3_v_r;
      if (rdy_out)   out_v_r <= p4_v_r;
      if (out_load)  held_r  <= head_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_tdata_r;

  `JADM_ASSERT_IMP(a_head_tracks_held, out_v_r, out_tdata_r[HEAD_LSB +: HEAD_W] == held_r, "output heading differs from held heading")
  `JADM_ASSERT_NEXT(a_filled_sticky, win_st.filled_now, win_st.filled_now, "window fill flag dropped")
  `JADM_ASSERT_IMP(a_percent_range, out_v_r, (out_tdata_r[SPEED_LSB +: SPEED_W] <= PERCENT_MAX) && (out_tdata_r[LIGHT_LSB +: LIGHT_W] <= PERCENT_MAX), "percentage above 100")

endmodule
